FILE: sv/msf_pkg.sv
// Shared sizes, codes and types for the message slot queue.
package msf_pkg;

   localparam int SLOTS      = 8;
   localparam int SLOT_BYTES = 32;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IDX_W  = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
   localparam int WIDX_W = $clog2(SLOT_BYTES + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int ADDR_W = SLOT_W + IDX_W;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int LEN_W  = 6;
   localparam int QCNT_W = 4;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSHED = 2'd0,
      KIND_POPPED = 2'd1,
      KIND_REJECT = 2'd2
   } kind_type;

   typedef enum logic {
      MODE_PUSH = 1'b0,
      MODE_POP  = 1'b1
   } mode_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_POP  = 1'b1
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_req_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_W'(SLOTS - 1)) begin
         r = '0;
      end else begin
         r = s + SLOT_W'(1);
      end
      return r;
   endfunction

endpackage

FILE: sv/msf_byte_ram.sv
// Simple dual-port byte memory with registered read data.
module msf_byte_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [(1 << ADDR_W)];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/msf_ctrl.sv
// Queue pointers, slot lengths, push/pop sequencing and the result register.
module msf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_mode,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [1:0]                 rsp_result_kind,
   output logic [7:0]                 rsp_out_byte,
   output logic [5:0]                 rsp_message_length,
   output logic [3:0]                 rsp_queue_count,
   output logic                       rsp_final_result,
   output msf_pkg::ram_req_type       ram_req,
   input  logic [msf_pkg::BYTE_W-1:0] ram_rd_data
);

   localparam int SLOTS      = msf_pkg::SLOTS;
   localparam int SLOT_BYTES = msf_pkg::SLOT_BYTES;
   localparam int SLOT_W     = msf_pkg::SLOT_W;
   localparam int IDX_W      = msf_pkg::IDX_W;
   localparam int WIDX_W     = msf_pkg::WIDX_W;
   localparam int CNT_W      = msf_pkg::CNT_W;
   localparam int BYTE_W     = msf_pkg::BYTE_W;
   localparam int LEN_W      = msf_pkg::LEN_W;
   localparam int QCNT_W     = msf_pkg::QCNT_W;

   msf_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [WIDX_W-1:0] widx_ff, widx_in;
   logic              drop_ff, drop_in;
   logic [WIDX_W-1:0] lens_ff [SLOTS];
   logic [WIDX_W-1:0] lens_in [SLOTS];

   logic [WIDX_W-1:0] pop_len_ff, pop_len_in;
   logic [CNT_W-1:0]  pop_cnt_ff, pop_cnt_in;
   logic [WIDX_W-1:0] iss_idx_ff, iss_idx_in;
   logic              pend_ff, pend_in;
   logic [WIDX_W-1:0] pend_idx_ff, pend_idx_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [QCNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;
   logic              rsp_fin_ff, rsp_fin_in;

   logic              req_acc;
   logic              can_load;
   logic              issue;
   logic              pop_start;
   logic              pop_done;
   logic              drop_now;
   logic              room;
   logic [WIDX_W-1:0] len_new;

   assign req_stall = (state_ff != msf_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_acc   = req_valid && !req_stall;
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == msf_pkg::ST_POP) && (iss_idx_ff != WIDX_W'(SLOT_BYTES))
                      && (!pend_ff || can_load);
   assign pop_start = req_acc && (req_mode == msf_pkg::MODE_POP) && (count_ff != '0);
   assign pop_done  = (state_ff == msf_pkg::ST_POP) && pend_ff && can_load
                      && (iss_idx_ff == WIDX_W'(SLOT_BYTES));
   assign drop_now  = drop_ff
                      || ((widx_ff == '0) && (count_ff == CNT_W'(SLOTS)));
   assign room      = widx_ff < WIDX_W'(SLOT_BYTES);
   assign len_new   = room ? (widx_ff + WIDX_W'(1)) : widx_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msf_pkg::ST_IDLE: begin
            if (pop_start) begin
               state_in = msf_pkg::ST_POP;
            end
         end
         msf_pkg::ST_POP: begin
            if (pop_done) begin
               state_in = msf_pkg::ST_IDLE;
            end
         end
         default: state_in = msf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      count_in    = count_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      widx_in     = widx_ff;
      drop_in     = drop_ff;
      lens_in     = lens_ff;
      pop_len_in  = pop_len_ff;
      pop_cnt_in  = pop_cnt_ff;
      iss_idx_in  = iss_idx_ff;
      pend_idx_in = pend_idx_ff;
      pend_in     = pend_ff && !can_load;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_fin_in  = rsp_fin_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_req     = '0;

      if (req_acc && (req_mode == msf_pkg::MODE_PUSH)) begin
         if (drop_now) begin
            drop_in = !req_last_byte;
            if (req_last_byte) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = msf_pkg::KIND_REJECT;
               rsp_byte_in  = '0;
               rsp_len_in   = '0;
               rsp_cnt_in   = QCNT_W'(count_ff);
               rsp_fin_in   = 1'b1;
            end
         end else begin
            if (room) begin
               ram_req.wr_en   = 1'b1;
               ram_req.wr_addr = {tail_ff, widx_ff[IDX_W-1:0]};
               ram_req.wr_data = req_data_byte;
               widx_in         = len_new;
            end
            if (req_last_byte) begin
               lens_in[tail_ff] = len_new;
               tail_in          = msf_pkg::next_slot(tail_ff);
               count_in         = count_ff + CNT_W'(1);
               widx_in          = '0;
               rsp_valid_in     = 1'b1;
               rsp_kind_in      = msf_pkg::KIND_PUSHED;
               rsp_byte_in      = '0;
               rsp_len_in       = LEN_W'(len_new);
               rsp_cnt_in       = QCNT_W'(count_ff + CNT_W'(1));
               rsp_fin_in       = 1'b1;
            end
         end
      end

      if (req_acc && (req_mode == msf_pkg::MODE_POP)) begin
         if (count_ff == '0) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = msf_pkg::KIND_REJECT;
            rsp_byte_in  = '0;
            rsp_len_in   = '0;
            rsp_cnt_in   = '0;
            rsp_fin_in   = 1'b1;
         end else begin
            count_in   = count_ff - CNT_W'(1);
            pop_cnt_in = count_ff - CNT_W'(1);
            pop_len_in = lens_ff[head_ff];
            iss_idx_in = '0;
         end
      end

      if (issue) begin
         ram_req.rd_en   = 1'b1;
         ram_req.rd_addr = {head_ff, iss_idx_ff[IDX_W-1:0]};
         iss_idx_in      = iss_idx_ff + WIDX_W'(1);
         pend_idx_in     = iss_idx_ff;
         pend_in         = 1'b1;
      end

      if ((state_ff == msf_pkg::ST_POP) && pend_ff && can_load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = msf_pkg::KIND_POPPED;
         rsp_byte_in  = (pend_idx_ff < pop_len_ff) ? ram_rd_data : '0;
         rsp_len_in   = LEN_W'(pop_len_ff);
         rsp_cnt_in   = QCNT_W'(pop_cnt_ff);
         rsp_fin_in   = (pend_idx_ff == WIDX_W'(SLOT_BYTES - 1));
      end

      if (pop_done) begin
         lens_in[head_ff] = '0;
         head_in          = msf_pkg::next_slot(head_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msf_pkg::ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         widx_ff      <= '0;
         drop_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            lens_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         widx_ff      <= widx_in;
         drop_ff      <= drop_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         lens_ff      <= lens_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_len_ff  <= pop_len_in;
      pop_cnt_ff  <= pop_cnt_in;
      iss_idx_ff  <= iss_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_out_byte       = rsp_byte_ff;
   assign rsp_message_length = rsp_len_ff;
   assign rsp_queue_count    = rsp_cnt_ff;
   assign rsp_final_result   = rsp_fin_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("queue count above slot total");

   a_widx_bound: assert property (@(posedge clock) disable iff (reset)
      widx_ff <= WIDX_W'(SLOT_BYTES))
      else $error("write index above slot capacity");

   a_pend_in_pop: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == msf_pkg::ST_POP))
      else $error("read pending outside pop");

   a_pop_done_final: assert property (@(posedge clock) disable iff (reset)
      pop_done |=> ((state_ff == msf_pkg::ST_IDLE) && rsp_valid_ff && rsp_fin_ff))
      else $error("pop ended without final word");

endmodule

FILE: sv/message_slot_fifo.sv
// Message slot queue: top level joining the sequencer and the byte memory.
//
// Input channel req_*: one word per message byte (req_mode push) with
// req_last_byte marking its end, or one word per pop (req_mode pop).
// Result channel rsp_*: a push result in the cycle after the final byte is
// accepted; a rejection in the cycle after a push ending a dropped message or
// a pop on an empty queue. A pop yields SLOT_BYTES words: the first passes
// through the pop state, a memory read and the result register, the rest
// follow one per cycle while rsp_stall is low; rsp_final_result marks the
// last word of each input. Pushed bytes are taken one per cycle while
// req_stall is low. A pop holds req_stall until its last word is loaded,
// as the byte memory has a single read port with registered read data.
// A full result register separates the channels; while rsp_stall holds
// it, req_stall rises and the memory read pipeline freezes in place.
// Reset empties the queue and zeroes all slot lengths at once; the byte
// memory is not cleared, bytes past a slot's stored length read as zero.
module message_slot_fifo (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_out_byte,
   output logic [5:0] rsp_message_length,
   output logic [3:0] rsp_queue_count,
   output logic       rsp_final_result
);

   msf_pkg::ram_req_type             ram_req;
   logic [msf_pkg::BYTE_W-1:0]       ram_rd_data;

   msf_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_message_length (rsp_message_length),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_final_result   (rsp_final_result),
      .ram_req            (ram_req),
      .ram_rd_data        (ram_rd_data)
   );

   msf_byte_ram #(
      .DATA_W (msf_pkg::BYTE_W),
      .ADDR_W (msf_pkg::ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

FILE: test/tb.sv
// Testbench for the message slot queue: table-driven and random words checked by a predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = msf_pkg::SLOTS;
   localparam int SLOT_BYTES  = msf_pkg::SLOT_BYTES;
   localparam int BYTE_W      = msf_pkg::BYTE_W;
   localparam int LEN_W       = msf_pkg::LEN_W;
   localparam int QCNT_W      = msf_pkg::QCNT_W;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 400;
   localparam int DRAIN_WAIT  = 2 * SLOT_BYTES + 8;
   localparam int N_ROWS      = 22;

   typedef struct packed {
      msf_pkg::kind_type kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  length;
      logic [QCNT_W-1:0] count;
      logic              fin;
   } slot_result_type;

   typedef struct {
      msf_pkg::mode_type mode;
      logic [BYTE_W-1:0] data;
      logic              last;
      int                reps;
      bit                typed;
      msf_pkg::kind_type kind;
      int                length;
      int                count;
   } dir_row_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_mode = msf_pkg::MODE_PUSH;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_out_byte;
   logic [5:0] rsp_message_length;
   logic [3:0] rsp_queue_count;
   logic       rsp_final_result;

   // model of the slot ring
   logic [BYTE_W-1:0] ring_bytes [SLOTS][SLOT_BYTES];
   int ring_len [SLOTS];
   int ring_head;
   int ring_tail;
   int ring_held;
   int fill_idx;
   bit discarding;

   slot_result_type op_results [$];
   slot_result_type due_results [$];

   int  idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   int  cycle_count;
   int  mismatches = 0;
   int  words_sent = 0;
   int  results_checked = 0;
   int  rejects_seen = 0;
   int  pops_seen = 0;

   dir_row_type dir_rows [N_ROWS] = '{
      '{msf_pkg::MODE_POP,  8'h00, 1'b0,  1, 1'b1, msf_pkg::KIND_REJECT,  0, 0},
      '{msf_pkg::MODE_PUSH, 8'h00, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  1, 1},
      '{msf_pkg::MODE_PUSH, 8'hFF, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  1, 2},
      '{msf_pkg::MODE_POP,  8'hFF, 1'b1,  1, 1'b0, msf_pkg::KIND_POPPED,  0, 0},
      '{msf_pkg::MODE_PUSH, 8'hF0, 1'b1, 34, 1'b1, msf_pkg::KIND_PUSHED, 32, 2},
      '{msf_pkg::MODE_PUSH, 8'h80, 1'b1, 32, 1'b1, msf_pkg::KIND_PUSHED, 32, 3},
      '{msf_pkg::MODE_PUSH, 8'h5A, 1'b1,  5, 1'b1, msf_pkg::KIND_PUSHED,  5, 4},
      '{msf_pkg::MODE_PUSH, 8'h01, 1'b1,  2, 1'b1, msf_pkg::KIND_PUSHED,  2, 5},
      '{msf_pkg::MODE_PUSH, 8'h7F, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  1, 6},
      '{msf_pkg::MODE_PUSH, 8'h40, 1'b0,  3, 1'b0, msf_pkg::KIND_PUSHED,  0, 0},
      '{msf_pkg::MODE_POP,  8'h00, 1'b0,  1, 1'b0, msf_pkg::KIND_POPPED,  0, 0},
      '{msf_pkg::MODE_PUSH, 8'h43, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  4, 6},
      '{msf_pkg::MODE_PUSH, 8'h55, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  1, 7},
      '{msf_pkg::MODE_PUSH, 8'hAA, 1'b1,  1, 1'b1, msf_pkg::KIND_PUSHED,  1, 8},
      '{msf_pkg::MODE_PUSH, 8'hEE, 1'b1,  4, 1'b1, msf_pkg::KIND_REJECT,  0, 8},
      '{msf_pkg::MODE_PUSH, 8'h77, 1'b1,  1, 1'b1, msf_pkg::KIND_REJECT,  0, 8},
      '{msf_pkg::MODE_PUSH, 8'h99, 1'b0,  2, 1'b0, msf_pkg::KIND_PUSHED,  0, 0},
      '{msf_pkg::MODE_POP,  8'h00, 1'b1,  1, 1'b0, msf_pkg::KIND_POPPED,  0, 0},
      '{msf_pkg::MODE_PUSH, 8'h9B, 1'b1,  1, 1'b1, msf_pkg::KIND_REJECT,  0, 7},
      '{msf_pkg::MODE_PUSH, 8'h3C, 1'b1,  3, 1'b1, msf_pkg::KIND_PUSHED,  3, 8},
      '{msf_pkg::MODE_POP,  8'h00, 1'b0,  8, 1'b0, msf_pkg::KIND_POPPED,  0, 0},
      '{msf_pkg::MODE_POP,  8'h00, 1'b0,  1, 1'b1, msf_pkg::KIND_REJECT,  0, 0}
   };

   message_slot_fifo i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_message_length (rsp_message_length),
      .rsp_queue_count    (rsp_queue_count),
      .rsp_final_result   (rsp_final_result)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic predict_slot_op(input msf_pkg::mode_type m, input logic [BYTE_W-1:0] d,
                                  input logic l);
      slot_result_type r;
      int i;
      op_results.delete();
      r.data = '0;
      r.fin  = 1'b1;
      if (m == msf_pkg::MODE_PUSH) begin
         if (fill_idx == 0 && !discarding && ring_held >= SLOTS) begin
            discarding = 1'b1;
         end
         if (discarding) begin
            if (l) begin
               discarding = 1'b0;
               r.kind   = msf_pkg::KIND_REJECT;
               r.length = '0;
               r.count  = QCNT_W'(ring_held);
               op_results.push_back(r);
            end
         end else begin
            if (fill_idx < SLOT_BYTES) begin
               ring_bytes[ring_tail][fill_idx] = d;
               fill_idx++;
            end
            if (l) begin
               ring_len[ring_tail] = fill_idx;
               ring_tail = (ring_tail == SLOTS - 1) ? 0 : ring_tail + 1;
               ring_held++;
               r.kind   = msf_pkg::KIND_PUSHED;
               r.length = LEN_W'(fill_idx);
               r.count  = QCNT_W'(ring_held);
               fill_idx = 0;
               op_results.push_back(r);
            end
         end
      end else if (ring_held == 0) begin
         r.kind   = msf_pkg::KIND_REJECT;
         r.length = '0;
         r.count  = '0;
         op_results.push_back(r);
      end else begin
         ring_held--;
         for (i = 0; i < SLOT_BYTES; i++) begin
            r.kind   = msf_pkg::KIND_POPPED;
            r.data   = ring_bytes[ring_head][i];
            r.length = LEN_W'(ring_len[ring_head]);
            r.count  = QCNT_W'(ring_held);
            r.fin    = (i == SLOT_BYTES - 1);
            op_results.push_back(r);
            ring_bytes[ring_head][i] = '0;
         end
         ring_len[ring_head] = 0;
         ring_head = (ring_head == SLOTS - 1) ? 0 : ring_head + 1;
      end
   endtask

   task automatic send_word(input msf_pkg::mode_type m, input logic [BYTE_W-1:0] d,
                            input logic l, input bit use_typed,
                            input slot_result_type typed_res);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= m;
      req_data_byte <= d;
      req_last_byte <= l;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      words_sent++;
      predict_slot_op(m, d, l);
      if (use_typed) begin
         due_results.push_back(typed_res);
      end else begin
         foreach (op_results[j]) due_results.push_back(op_results[j]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic random_traffic(input int n_words, input int pop_pct);
      slot_result_type none;
      int sent;
      int len;
      int k;
      int pick;
      none = '0;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(99) < pop_pct) begin
            send_word(msf_pkg::MODE_POP, 8'($urandom), 1'($urandom), 1'b0, none);
            sent++;
         end else begin
            pick = $urandom_range(99);
            if (pick < 80) begin
               len = $urandom_range(3, 1);
            end else if (pick < 95) begin
               len = $urandom_range(31, 4);
            end else begin
               len = $urandom_range(36, 32);
            end
            for (k = 0; k < len; k++) begin
               if (k > 0 && $urandom_range(99) < 6) begin
                  send_word(msf_pkg::MODE_POP, 8'($urandom), 1'($urandom), 1'b0, none);
                  sent++;
               end
               send_word(msf_pkg::MODE_PUSH, 8'($urandom), k == len - 1, 1'b0, none);
               sent++;
            end
         end
      end
   endtask

   // receiver stall, with an occasional long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      slot_result_type exp_res;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word: kind %0d byte %02h len %0d count %0d final %0d",
                        rsp_result_kind, rsp_out_byte, rsp_message_length,
                        rsp_queue_count, rsp_final_result);
            end
         end else begin
            exp_res = due_results.pop_front();
            results_checked++;
            if (exp_res.kind == msf_pkg::KIND_REJECT) rejects_seen++;
            if (exp_res.kind == msf_pkg::KIND_POPPED) pops_seen++;
            if (rsp_result_kind !== exp_res.kind || rsp_out_byte !== exp_res.data ||
                rsp_message_length !== exp_res.length || rsp_queue_count !== exp_res.count ||
                rsp_final_result !== exp_res.fin) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d: exp kind %0d byte %02h len %0d cnt %0d fin %0d",
                           cycle_count, exp_res.kind, exp_res.data, exp_res.length,
                           exp_res.count, exp_res.fin);
                  $display("                        got kind %0d byte %02h len %0d cnt %0d fin %0d",
                           rsp_result_kind, rsp_out_byte, rsp_message_length,
                           rsp_queue_count, rsp_final_result);
               end
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               due_results.size());
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      slot_result_type typed_res;
      bit fin_rep;
      int i;
      int k;
      for (i = 0; i < SLOTS; i++) begin
         ring_len[i] = 0;
         for (k = 0; k < SLOT_BYTES; k++) ring_bytes[i][k] = '0;
      end
      ring_head  = 0;
      ring_tail  = 0;
      ring_held  = 0;
      fill_idx   = 0;
      discarding = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_ROWS; i++) begin
         for (k = 0; k < dir_rows[i].reps; k++) begin
            fin_rep          = (k == dir_rows[i].reps - 1);
            typed_res.kind   = dir_rows[i].kind;
            typed_res.data   = '0;
            typed_res.length = LEN_W'(dir_rows[i].length);
            typed_res.count  = QCNT_W'(dir_rows[i].count);
            typed_res.fin    = 1'b1;
            send_word(dir_rows[i].mode, 8'(dir_rows[i].data + k),
                      dir_rows[i].last && fin_rep, dir_rows[i].typed && fin_rep, typed_res);
         end
      end
      wait_drained();

      // no idling; long receiver hold-off while the sender keeps going
      hold_request = 1'b1;
      random_traffic(45, 10);
      random_traffic(25, 65);
      wait_drained();

      idle_pct  = 47;
      stall_pct = 0;
      random_traffic(45, 10);
      random_traffic(25, 65);
      wait_drained();

      idle_pct  = 0;
      stall_pct = 47;
      random_traffic(45, 10);
      random_traffic(25, 65);
      wait_drained();

      idle_pct  = 9;
      stall_pct = 9;
      random_traffic(45, 10);
      random_traffic(25, 65);
      wait_drained();

      stall_pct = 0;
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("sent %0d words, checked %0d results (%0d popped bytes, %0d rejections)",
               words_sent, results_checked, pops_seen, rejects_seen);
      $display("covered overlong and dropped messages, pops on empty and mid-message, %0d errors",
               mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
